// ===== hdl/three_way_hash_bucket_unit_defines.svh =====
// Assertion macros shared by the bucket RTL.
`ifndef THREE_WAY_HASH_BUCKET_UNIT_DEFINES_SVH
`define THREE_WAY_HASH_BUCKET_UNIT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define TWHB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("twhb assertion failed");

// Checked on every rising edge, reset included.
`define TWHB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("twhb assertion failed");

`endif

// ===== hdl/twhb_pkg.sv =====
`timescale 1ns / 1ps

package twhb_pkg;

  localparam int unsigned WAYS_DEFAULT = 3;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned PGATE_W  = 2;
  localparam int unsigned STATUS_W = 3;

  // Request: mode, key, new_value, put_gate, remove_gate; padded to bytes.
  localparam int unsigned IN_BITS     = MODE_W + KEY_W + VALUE_W + PGATE_W + 1;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = STATUS_W + VALUE_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT    = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [PGATE_W-1:0] {
    PG_ALLOW    = 2'd0,
    PG_FAIL     = 2'd1,
    PG_NO_SPACE = 2'd2
  } pgate_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_REFUSED   = 3'd4
  } status_e;

  localparam logic RG_REFUSE = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] new_value;
    logic [PGATE_W-1:0] put_gate;
    logic               remove_gate;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] read_value;
  } res_t;

endpackage

// ===== hdl/three_way_hash_bucket_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  request: mode, key, value, gates
// m_axis    out        m_axis_tvalid/m_axis_tready  result: status, read value
//
// One request per cycle is sustained while m_axis accepts results; a request taken
// passes the input register, then the result register, before it is valid on m_axis.
// The slot compare and priority pick are combinational between the input register
// and the result register; the slot update is written at the same edge as the result.
// Reset clears every slot to empty with a zero value and drops both valids.
// While the result waits, one further request is held in the input register.

module three_way_hash_bucket_unit #(
  parameter int unsigned WAYS = twhb_pkg::WAYS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [1:0] mode, [65:2] key, [129:66] new_value, [131:130] put_gate,
  // [132] remove_gate, [135:133] zero
  input  logic [twhb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] status, [66:3] read_value, [71:67] zero
  output logic [twhb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  twhb_pkg::req_t in_q;
  twhb_pkg::req_t in_d;
  logic           in_valid_q;
  logic           in_valid_d;
  twhb_pkg::res_t out_q;
  twhb_pkg::res_t res;
  logic           out_valid_q;
  logic           out_valid_d;
  logic           advance;
  logic           take;

  assign in_d.mode        = s_axis_tdata[twhb_pkg::MODE_W-1:0];
  assign in_d.key         = s_axis_tdata[twhb_pkg::MODE_W +: twhb_pkg::KEY_W];
  assign in_d.new_value   = s_axis_tdata[twhb_pkg::MODE_W + twhb_pkg::KEY_W +:
                                         twhb_pkg::VALUE_W];
  assign in_d.put_gate    = s_axis_tdata[twhb_pkg::MODE_W + twhb_pkg::KEY_W +
                                         twhb_pkg::VALUE_W +: twhb_pkg::PGATE_W];
  assign in_d.remove_gate = s_axis_tdata[twhb_pkg::IN_BITS-1];

  // The held request moves on whenever the result register is free or drains.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign take          = s_axis_tvalid & s_axis_tready;
  assign in_valid_d    = take | (in_valid_q & ~advance);
  assign out_valid_d   = advance | (out_valid_q & ~m_axis_tready);

  twhb_bucket #(
    .WAYS(WAYS)
  ) u_bucket (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (in_q),
    .fire_i(advance),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(twhb_pkg::OUT_TDATA_W - twhb_pkg::OUT_BITS){1'b0}},
                          out_q.read_value, out_q.status};

endmodule

// ===== hdl/twhb_bucket.sv =====
`timescale 1ns / 1ps
`include "three_way_hash_bucket_unit_defines.svh"

module twhb_bucket #(
  parameter int unsigned WAYS = twhb_pkg::WAYS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  twhb_pkg::req_t   req_i,
  input  logic             fire_i,
  output twhb_pkg::res_t   res_o
);

  logic [twhb_pkg::KEY_W-1:0]   keys_q   [WAYS];
  logic [twhb_pkg::VALUE_W-1:0] values_q [WAYS];

  logic [WAYS-1:0] empty;
  logic [WAYS-1:0] hit;
  logic [WAYS-1:0] empty_first;
  logic [WAYS-1:0] hit_first;
  logic [WAYS-1:0] key_wr;
  logic [WAYS-1:0] val_wr;
  logic [twhb_pkg::VALUE_W-1:0] hit_value;
  logic [twhb_pkg::KEY_W-1:0]   key_wdata;
  logic [twhb_pkg::VALUE_W-1:0] val_wdata;

  // All slots are compared at once; a priority pick keeps the lowest slot.
  always_comb begin
    logic empty_seen;
    logic hit_seen;
    empty_seen = 1'b0;
    hit_seen   = 1'b0;
    hit_value  = '0;
    for (int i = 0; i < WAYS; i++) begin
      empty[i]       = (keys_q[i] == '0);
      hit[i]         = (keys_q[i] == req_i.key);
      empty_first[i] = empty[i] & ~empty_seen;
      hit_first[i]   = hit[i] & ~hit_seen;
      empty_seen     = empty_seen | empty[i];
      hit_seen       = hit_seen | hit[i];
      hit_value      = hit_value | (values_q[i] & {twhb_pkg::VALUE_W{hit_first[i]}});
    end
  end

  always_comb begin
    key_wr           = '0;
    val_wr           = '0;
    key_wdata        = '0;
    val_wdata        = '0;
    res_o.status     = twhb_pkg::ST_NOT_FOUND;
    res_o.read_value = '0;
    case (twhb_pkg::mode_e'(req_i.mode))
      twhb_pkg::MODE_PUT: begin
        key_wdata = req_i.key;
        val_wdata = req_i.new_value;
        if (~|empty) begin
          res_o.status = twhb_pkg::ST_FULL;
        end else begin
          case (twhb_pkg::pgate_e'(req_i.put_gate))
            twhb_pkg::PG_ALLOW: begin
              key_wr       = empty_first;
              val_wr       = empty_first;
              res_o.status = twhb_pkg::ST_DONE;
            end
            twhb_pkg::PG_NO_SPACE: res_o.status = twhb_pkg::ST_NO_SPACE;
            twhb_pkg::PG_FAIL:     res_o.status = twhb_pkg::ST_REFUSED;
            default:               res_o.status = twhb_pkg::ST_REFUSED;
          endcase
        end
      end
      twhb_pkg::MODE_FIND: begin
        if (|hit) begin
          res_o.status     = twhb_pkg::ST_DONE;
          res_o.read_value = hit_value;
        end
      end
      twhb_pkg::MODE_REMOVE: begin
        if (|hit) begin
          res_o.read_value = hit_value;
          key_wr           = hit_first;
          // A refused remove still frees the slot but keeps its value.
          if (req_i.remove_gate == twhb_pkg::RG_REFUSE) begin
            res_o.status = twhb_pkg::ST_REFUSED;
          end else begin
            val_wr       = hit_first;
            res_o.status = twhb_pkg::ST_DONE;
          end
        end
      end
      default: begin
        res_o.status = twhb_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WAYS; i++) begin
        keys_q[i]   <= '0;
        values_q[i] <= '0;
      end
    end else if (fire_i) begin
      for (int i = 0; i < WAYS; i++) begin
        if (key_wr[i]) begin
          keys_q[i] <= key_wdata;
        end
        if (val_wr[i]) begin
          values_q[i] <= val_wdata;
        end
      end
    end
  end

  `TWHB_ASSERT_ALWAYS(a_single_slot_written, $onehot0(key_wr) && $onehot0(val_wr))
  `TWHB_ASSERT(a_full_means_no_empty,
               res_o.status == twhb_pkg::ST_FULL |-> ~|empty)
  `TWHB_ASSERT(a_find_leaves_store,
               fire_i && req_i.mode == twhb_pkg::MODE_FIND |=> $stable(empty))
  `TWHB_ASSERT(a_miss_reads_zero,
               res_o.status == twhb_pkg::ST_NOT_FOUND |-> res_o.read_value == '0)

endmodule
